// ----- src/console_controller_registers_unit_defines.svh -----
// assertion macros for the console controller register unit
// used by the checker; no other dependencies
`ifndef CONSOLE_CONTROLLER_REGISTERS_UNIT_DEFINES_SVH
`define CONSOLE_CONTROLLER_REGISTERS_UNIT_DEFINES_SVH

// concurrent check, switched off while reset is high
`define CCR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// concurrent check that also holds around reset
`define CCR_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/ccr_pkg.sv -----
// shared types, codes and helpers of the console controller register unit
// no dependencies
`timescale 1ns / 1ps

package ccr_pkg;

   // receive queue depth default
   localparam int RX_DEPTH_DEFAULT = 16;

   // item kinds
   localparam logic [2:0] CMD_CONTROL  = 3'd0;
   localparam logic [2:0] CMD_SKIP     = 3'd1;
   localparam logic [2:0] CMD_INPUT    = 3'd2;
   localparam logic [2:0] CMD_OUTPUT   = 3'd3;
   localparam logic [2:0] CMD_KEYBOARD = 3'd4;

   // control functions
   localparam logic [3:0] F_CTL_ECHO_OFF  = 4'o10;
   localparam logic [3:0] F_CTL_ECHO_ON   = 4'o12;
   localparam logic [3:0] F_CTL_MASK_ON   = 4'o15;
   localparam logic [3:0] F_CTL_MASK_OFF  = 4'o16;
   localparam logic [3:0] F_CTL_MASK_OFF2 = 4'o17;

   // skip functions
   localparam logic [3:0] F_SKP_RX_READY = 4'o04;

   // input functions
   localparam logic [3:0] F_INA_CHAR_OR  = 4'o00;
   localparam logic [3:0] F_INA_CHAR_LD  = 4'o10;
   localparam logic [3:0] F_INA_REG0     = 4'o04;
   localparam logic [3:0] F_INA_REG3     = 4'o07;
   localparam logic [3:0] F_INA_ID       = 4'o11;
   localparam logic [3:0] F_INA_CLOCK    = 4'o17;

   // output functions
   localparam logic [3:0] F_OTA_CHAR     = 4'o00;
   localparam logic [3:0] F_OTA_REG0     = 4'o04;
   localparam logic [3:0] F_OTA_REG3     = 4'o07;
   localparam logic [3:0] F_OTA_RX_VEC   = 4'o16;
   localparam logic [3:0] F_OTA_CLOCK    = 4'o17;

   // constants
   localparam logic [15:0] DEVICE_ID_RESET = 16'o104;
   localparam logic [15:0] YEAR_HIGH_MARK  = 16'o240;
   localparam logic [7:0]  CHAR_BIT7       = 8'h80;
   localparam logic [5:0]  SECOND_MAX      = 6'd59;
   localparam logic [3:0]  CLOCK_IDLE      = 4'd8;

   // one input item
   typedef struct packed {
      logic [2:0]  cmd;
      logic [3:0]  func;
      logic [15:0] a_data;
      logic [6:0]  rx_char;
      logic [7:0]  year_since_1900;
      logic [3:0]  month_zero_based;
      logic [4:0]  day_of_month;
      logic [2:0]  weekday_zero_based;
      logic [4:0]  hour_of_day;
      logic [5:0]  minute_of_hour;
      logic [5:0]  second_of_minute;
   } req_type;

   // one result item
   typedef struct packed {
      logic [15:0] a_out;
      logic        a_write;
      logic        done_flag;
      logic        tx_valid;
      logic [6:0]  tx_char;
      logic        rx_irq;
      logic [15:0] irq_vector;
   } rsp_type;

   // two low decimal digits of an 8-bit value, by shift-and-add-3
   function automatic logic [7:0] bcd_low2(input logic [7:0] v);
      logic [11:0] digits;
      digits = '0;
      for (int i = 7; i >= 0; i--) begin
         for (int d = 0; d < 3; d++) begin
            if (digits[d*4 +: 4] >= 4'd5) begin
               digits[d*4 +: 4] = digits[d*4 +: 4] + 4'd3;
            end
         end
         digits = {digits[10:0], v[i]};
      end
      return digits[7:0];
   endfunction

endpackage

// ----- src/ccr_ram.sv -----
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`timescale 1ns / 1ps

module ccr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read, old data on a collision
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/console_controller_registers_unit.sv -----
// console controller register unit, top level
// depends on ccr_pkg and ccr_ram
`timescale 1ns / 1ps

// Serial console controller at register level. Each request item is one I/O
// order from the processor (control, skip test, input, output) or one
// keyboard character arriving into the receive queue; each produces exactly
// one response item with the new accumulator value, the done flag, an
// optional printer character and the receive interrupt state.
// Channels: req_/rsp_ use valid and stall; an item moves on an edge with
// valid high and stall low. The device ID register is written through
// csr_wr_en / csr_wr_data; the user must do so only while the unit is
// idle; the unit does not enforce it. An accepted request passes the input
// register, then the result register. Throughput: one item per cycle while
// rsp_stall stays low; the decode between the two registers is a single
// pass, and the receive queue ram is read ahead at the next head address.
// Reset (synchronous, active high) empties both stages, the receive queue
// and all control state, and restores the device ID to its default.
// A stalled response holds its register; the input stage then fills and
// req_stall rises until the response is taken.
module console_controller_registers_unit #(
   parameter int RX_DEPTH = ccr_pkg::RX_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ccr_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ccr_pkg::rsp_type rsp_payload,
   input  logic             csr_wr_en,
   input  logic [15:0]      csr_wr_data
);

   localparam int AW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
   localparam int CW = $clog2(RX_DEPTH + 1);

   // pipeline registers
   logic             s1_valid_ff;
   ccr_pkg::req_type s1_item_ff;
   logic             rsp_valid_ff;
   ccr_pkg::rsp_type rsp_item_ff;
   ccr_pkg::rsp_type rsp_item_in;
   logic             advance;
   logic             process;
   logic             accept;

   // control state
   logic [15:0] device_id_ff;
   logic        echo_ff, echo_in;
   logic        mask_ff, mask_in;
   logic        pend_ff, pend_in;
   logic [15:0] pvec_ff, pvec_in;
   logic [15:0] rxvec_ff, rxvec_in;
   logic [15:0] txvec_ff, txvec_in;
   logic [15:0] ctrl_ff [4];
   logic [15:0] ctrl_in [4];
   logic [15:0] cw_ff [8];
   logic [15:0] cw_in [8];
   logic        cw_load;
   logic [3:0]  cidx_ff, cidx_in;

   // receive queue pointers
   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW:0]   tail_sum;
   logic [AW-1:0] tail;
   logic          q_empty, q_full;

   // queue ram ports and read bypass
   logic          ram_wr_en;
   logic [6:0]    ram_rd_data;
   logic          fwd_ff;
   logic [6:0]    fwd_data_ff;
   logic [6:0]    pop_char;

   // snapshot words from the time fields
   logic [15:0] snap [8];
   logic [5:0]  sec_clip;

   // handshake
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign process   = s1_valid_ff && advance;
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   // queue status and write position
   assign q_empty  = (count_ff == '0);
   assign q_full   = (count_ff == CW'(RX_DEPTH));
   assign tail_sum = (CW+1)'(head_ff) + (CW+1)'(count_ff);
   assign tail     = (tail_sum >= (CW+1)'(RX_DEPTH)) ?
                     AW'(tail_sum - (CW+1)'(RX_DEPTH)) : AW'(tail_sum);
   assign pop_char = fwd_ff ? fwd_data_ff : ram_rd_data;
   assign ram_wr_en = process && (s1_item_ff.cmd == ccr_pkg::CMD_KEYBOARD) && !q_full;

   // clock snapshot encoding
   assign sec_clip = (s1_item_ff.second_of_minute > ccr_pkg::SECOND_MAX) ?
                     ccr_pkg::SECOND_MAX : s1_item_ff.second_of_minute;

   always_comb begin
      snap[0] = {8'h00, ccr_pkg::bcd_low2(s1_item_ff.year_since_1900)};
      if (s1_item_ff.year_since_1900 > 8'd99 && s1_item_ff.year_since_1900 < 8'd128) begin
         snap[0] = snap[0] + ccr_pkg::YEAR_HIGH_MARK;
      end
      snap[1] = {8'h00, ccr_pkg::bcd_low2(8'(s1_item_ff.month_zero_based) + 8'd1)};
      snap[2] = {8'h00, ccr_pkg::bcd_low2(8'(s1_item_ff.day_of_month))};
      snap[3] = {8'h00, ccr_pkg::bcd_low2(8'(s1_item_ff.weekday_zero_based) + 8'd1)};
      snap[4] = {8'h00, ccr_pkg::bcd_low2(8'(s1_item_ff.hour_of_day))};
      snap[5] = {8'h00, ccr_pkg::bcd_low2(8'(s1_item_ff.minute_of_hour))};
      snap[6] = {8'h00, ccr_pkg::bcd_low2(8'(sec_clip))};
      snap[7] = '0;
   end

   // order decode and next state
   always_comb begin
      echo_in  = echo_ff;
      mask_in  = mask_ff;
      pend_in  = pend_ff;
      pvec_in  = pvec_ff;
      rxvec_in = rxvec_ff;
      txvec_in = txvec_ff;
      ctrl_in  = ctrl_ff;
      cw_in    = snap;
      cw_load  = 1'b0;
      cidx_in  = cidx_ff;
      head_in  = head_ff;
      count_in = count_ff;
      rsp_item_in = '0;

      if (process) begin
         unique case (s1_item_ff.cmd)
            ccr_pkg::CMD_CONTROL: begin
               unique case (s1_item_ff.func) inside
                  ccr_pkg::F_CTL_ECHO_OFF: echo_in = 1'b0;
                  ccr_pkg::F_CTL_ECHO_ON:  echo_in = 1'b1;
                  ccr_pkg::F_CTL_MASK_ON: begin
                     mask_in = 1'b1;
                     if (!q_empty) begin
                        pend_in = 1'b1;
                        pvec_in = rxvec_ff;
                     end
                  end
                  ccr_pkg::F_CTL_MASK_OFF, ccr_pkg::F_CTL_MASK_OFF2: begin
                     mask_in = 1'b0;
                     pend_in = 1'b0;
                  end
                  default: ;
               endcase
            end
            ccr_pkg::CMD_SKIP: begin
               rsp_item_in.done_flag =
                  !(s1_item_ff.func == ccr_pkg::F_SKP_RX_READY && !q_empty);
            end
            ccr_pkg::CMD_INPUT: begin
               rsp_item_in.done_flag = 1'b1;
               unique case (s1_item_ff.func) inside
                  ccr_pkg::F_INA_CHAR_OR, ccr_pkg::F_INA_CHAR_LD: begin
                     if (q_empty) begin
                        rsp_item_in.done_flag = 1'b0;
                     end else begin
                        head_in  = (head_ff == AW'(RX_DEPTH - 1)) ? '0 : head_ff + AW'(1);
                        count_in = count_ff - CW'(1);
                        if (echo_ff) begin
                           rsp_item_in.tx_valid = 1'b1;
                           rsp_item_in.tx_char  = pop_char;
                        end
                        rsp_item_in.a_write = 1'b1;
                        if (s1_item_ff.func == ccr_pkg::F_INA_CHAR_OR) begin
                           rsp_item_in.a_out = s1_item_ff.a_data |
                                               {8'h00, ccr_pkg::CHAR_BIT7 | {1'b0, pop_char}};
                        end else begin
                           rsp_item_in.a_out = {8'h00, ccr_pkg::CHAR_BIT7 | {1'b0, pop_char}};
                        end
                     end
                  end
                  [ccr_pkg::F_INA_REG0:ccr_pkg::F_INA_REG3]: begin
                     rsp_item_in.a_write = 1'b1;
                     rsp_item_in.a_out   = ctrl_ff[s1_item_ff.func[1:0]];
                  end
                  ccr_pkg::F_INA_ID: begin
                     rsp_item_in.a_write = 1'b1;
                     rsp_item_in.a_out   = device_id_ff;
                  end
                  ccr_pkg::F_INA_CLOCK: begin
                     rsp_item_in.a_write = 1'b1;
                     if (cidx_ff < ccr_pkg::CLOCK_IDLE) begin
                        rsp_item_in.a_out = cw_ff[cidx_ff[2:0]];
                        cidx_in = cidx_ff + 4'd1;
                     end else begin
                        rsp_item_in.a_out = txvec_ff;
                     end
                  end
                  default: ;
               endcase
            end
            ccr_pkg::CMD_OUTPUT: begin
               rsp_item_in.done_flag = 1'b1;
               unique case (s1_item_ff.func) inside
                  ccr_pkg::F_OTA_CHAR: begin
                     rsp_item_in.tx_valid = 1'b1;
                     rsp_item_in.tx_char  = s1_item_ff.a_data[6:0];
                  end
                  [ccr_pkg::F_OTA_REG0:ccr_pkg::F_OTA_REG3]: begin
                     ctrl_in[s1_item_ff.func[1:0]] = s1_item_ff.a_data;
                  end
                  ccr_pkg::F_OTA_RX_VEC: rxvec_in = s1_item_ff.a_data;
                  ccr_pkg::F_OTA_CLOCK: begin
                     if (s1_item_ff.a_data == '0) begin
                        cw_load = 1'b1;
                        cidx_in = '0;
                     end else begin
                        cidx_in  = ccr_pkg::CLOCK_IDLE;
                        txvec_in = s1_item_ff.a_data;
                     end
                  end
                  default: ;
               endcase
            end
            ccr_pkg::CMD_KEYBOARD: begin
               if (mask_ff) begin
                  pend_in = 1'b1;
                  pvec_in = rxvec_ff;
               end
               if (!q_full) begin
                  count_in = count_ff + CW'(1);
               end
            end
            default: ;
         endcase

         // interrupt state after this item, shown for every kind of item
         rsp_item_in.rx_irq     = pend_in;
         rsp_item_in.irq_vector = pend_in ? pvec_in : '0;
      end
   end

   // receive queue storage
   ccr_ram #(
      .WIDTH (7),
      .DEPTH (RX_DEPTH)
   ) u_rx_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (tail),
      .wr_data (s1_item_ff.rx_char),
      .rd_addr (head_in),
      .rd_data (ram_rd_data)
   );

   // input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (process) begin
         s1_valid_ff <= 1'b0;
      end
      if (accept) begin
         s1_item_ff <= req_payload;
      end
   end

   // result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
      if (process) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   // read bypass when the queue write hits the next read address
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else begin
         fwd_ff <= ram_wr_en && (tail == head_in);
      end
      fwd_data_ff <= s1_item_ff.rx_char;
   end

   // control state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         device_id_ff <= ccr_pkg::DEVICE_ID_RESET;
         echo_ff      <= 1'b0;
         mask_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         pvec_ff      <= '0;
         rxvec_ff     <= '0;
         txvec_ff     <= '0;
         for (int i = 0; i < 4; i++) begin
            ctrl_ff[i] <= '0;
         end
         cidx_ff      <= ccr_pkg::CLOCK_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
      end else begin
         if (csr_wr_en) begin
            device_id_ff <= csr_wr_data;
         end
         echo_ff  <= echo_in;
         mask_ff  <= mask_in;
         pend_ff  <= pend_in;
         pvec_ff  <= pvec_in;
         rxvec_ff <= rxvec_in;
         txvec_ff <= txvec_in;
         ctrl_ff  <= ctrl_in;
         cidx_ff  <= cidx_in;
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // snapshot words, only read after a snapshot has been taken
   always_ff @(posedge clock) begin
      if (cw_load) begin
         cw_ff <= cw_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_item_ff;

endmodule

// ----- src/ccr_checker.sv -----
// port-level checks for the console controller register unit, with bind
// depends on ccr_pkg and console_controller_registers_unit_defines.svh
`timescale 1ns / 1ps
`include "console_controller_registers_unit_defines.svh"

module ccr_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input ccr_pkg::rsp_type rsp_payload
);

   // a stalled response item stays offered
   `CCR_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid, "rsp item dropped")

   // a stalled response item keeps its payload
   `CCR_ASSERT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall |=> $stable(rsp_payload), "rsp moved")

   // no response item right after reset
   `CCR_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "rsp valid after reset")

   // with the result register free the unit takes a new item
   `CCR_ASSERT(a_no_stall_drained, clock, reset, !rsp_valid |-> !req_stall, "req stalled")

endmodule

bind console_controller_registers_unit ccr_checker u_ccr_checker (.*);

// ----- tb/tb_console_controller_registers_unit.sv -----
// self-checking testbench for the console controller register unit
// depends on ccr_pkg and the console_controller_registers_unit rtl
// predicts each response from a model of the console state and compares it
`timescale 1ns / 1ps

module tb_console_controller_registers_unit;
   import ccr_pkg::*;

   // codes with no name in the package
   localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
   localparam logic [2:0] CMD_UNUSED_HI = 3'd7;
   localparam logic [3:0] F_CTL_NOP     = 4'o01;
   localparam logic [3:0] F_SKP_ANY     = 4'o17;
   localparam logic [3:0] F_OTA_NOP     = 4'o13;
   localparam int         QUEUE_DEPTH   = RX_DEPTH_DEFAULT;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_payload = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_payload;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = '0;

   // console state as the predictor sees it
   logic [15:0] id_model;
   logic [6:0]  kb_queue[$];
   logic        echo_model;
   logic        mask_model;
   logic        irq_model;
   logic [15:0] latched_vec;
   logic [15:0] rx_vec_model;
   logic [15:0] tx_vec_model;
   logic [15:0] ctl_model[4];
   logic [15:0] clk_words[8];
   int unsigned clk_ptr;

   rsp_type     responses_due[$];
   int unsigned mismatch_count = 0;
   int unsigned items_sent = 0;
   logic        req_calm = 1'b0;
   logic        rsp_calm = 1'b0;
   int unsigned stall_left = 0;

   console_controller_registers_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // two decimal digits, bcd coded
   function automatic logic [15:0] bcd2(input int unsigned v);
      return 16'((((v / 10) % 10) << 4) | (v % 10));
   endfunction

   function automatic void raise_irq_model();
      irq_model = 1'b1;
      latched_vec = rx_vec_model;
   endfunction

   // next response of the console for one item, updating the state
   function automatic rsp_type console_predict(input req_type r);
      rsp_type     o;
      int unsigned yr;
      int unsigned sec;
      logic [6:0]  c;
      o = '0;
      case (r.cmd)
         CMD_CONTROL: begin
            if (r.func == F_CTL_ECHO_OFF) echo_model = 1'b0;
            else if (r.func == F_CTL_ECHO_ON) echo_model = 1'b1;
            else if (r.func == F_CTL_MASK_ON) begin
               mask_model = 1'b1;
               if (kb_queue.size() > 0) raise_irq_model();
            end else if (r.func == F_CTL_MASK_OFF || r.func == F_CTL_MASK_OFF2) begin
               mask_model = 1'b0;
               irq_model = 1'b0;
            end
         end
         CMD_SKIP: begin
            o.done_flag = !(r.func == F_SKP_RX_READY && kb_queue.size() > 0);
         end
         CMD_INPUT: begin
            o.done_flag = 1'b1;
            if (r.func == F_INA_CHAR_OR || r.func == F_INA_CHAR_LD) begin
               if (kb_queue.size() == 0) begin
                  o.done_flag = 1'b0;
               end else begin
                  c = kb_queue.pop_front();
                  if (echo_model) begin
                     o.tx_valid = 1'b1;
                     o.tx_char = c;
                  end
                  o.a_write = 1'b1;
                  o.a_out = {8'h00, 1'b1, c};
                  if (r.func == F_INA_CHAR_OR) o.a_out = o.a_out | r.a_data;
               end
            end else if (r.func >= F_INA_REG0 && r.func <= F_INA_REG3) begin
               o.a_write = 1'b1;
               o.a_out = ctl_model[r.func[1:0]];
            end else if (r.func == F_INA_ID) begin
               o.a_write = 1'b1;
               o.a_out = id_model;
            end else if (r.func == F_INA_CLOCK) begin
               o.a_write = 1'b1;
               if (clk_ptr < 8) begin
                  o.a_out = clk_words[clk_ptr];
                  clk_ptr++;
               end else begin
                  o.a_out = tx_vec_model;
               end
            end
         end
         CMD_OUTPUT: begin
            o.done_flag = 1'b1;
            if (r.func == F_OTA_CHAR) begin
               o.tx_valid = 1'b1;
               o.tx_char = r.a_data[6:0];
            end else if (r.func >= F_OTA_REG0 && r.func <= F_OTA_REG3) begin
               ctl_model[r.func[1:0]] = r.a_data;
            end else if (r.func == F_OTA_RX_VEC) begin
               rx_vec_model = r.a_data;
            end else if (r.func == F_OTA_CLOCK) begin
               if (r.a_data == 16'h0000) begin
                  // snapshot of the wall time
                  yr = r.year_since_1900;
                  sec = r.second_of_minute;
                  if (sec > SECOND_MAX) sec = SECOND_MAX;
                  clk_words[0] = bcd2(yr) + ((yr > 99 && yr < 128) ? YEAR_HIGH_MARK : 16'h0);
                  clk_words[1] = bcd2(int'(r.month_zero_based) + 1);
                  clk_words[2] = bcd2(r.day_of_month);
                  clk_words[3] = bcd2(int'(r.weekday_zero_based) + 1);
                  clk_words[4] = bcd2(r.hour_of_day);
                  clk_words[5] = bcd2(r.minute_of_hour);
                  clk_words[6] = bcd2(sec);
                  clk_words[7] = 16'h0000;
                  clk_ptr = 0;
               end else begin
                  clk_ptr = CLOCK_IDLE;
                  tx_vec_model = r.a_data;
               end
            end
         end
         CMD_KEYBOARD: begin
            if (mask_model) raise_irq_model();
            if (kb_queue.size() < QUEUE_DEPTH) kb_queue.push_back(r.rx_char);
         end
         default: begin
         end
      endcase
      o.rx_irq = irq_model;
      o.irq_vector = irq_model ? latched_vec : 16'h0000;
      return o;
   endfunction

   function automatic void clear_model();
      id_model = DEVICE_ID_RESET;
      kb_queue.delete();
      echo_model = 1'b0;
      mask_model = 1'b0;
      irq_model = 1'b0;
      latched_vec = '0;
      rx_vec_model = '0;
      tx_vec_model = '0;
      foreach (ctl_model[i]) ctl_model[i] = '0;
      foreach (clk_words[i]) clk_words[i] = '0;
      clk_ptr = CLOCK_IDLE;
   endfunction

   // predict on every accepted item, track device id writes
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_wr_en) id_model = csr_wr_data;
         if (req_valid && !req_stall) responses_due.push_back(console_predict(req_payload));
      end
   end

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         mismatch_count++;
         $display("%0t: %s expected %h actual %h", $time, name, want, got);
      end
   endfunction

   // compare each accepted response with the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (responses_due.size() == 0) begin
            mismatch_count++;
            $display("%0t: response with none expected, actual %h", $time, rsp_payload);
         end else begin
            want = responses_due.pop_front();
            check_field("a_out", want.a_out, rsp_payload.a_out);
            check_field("a_write", want.a_write, rsp_payload.a_write);
            check_field("done_flag", want.done_flag, rsp_payload.done_flag);
            check_field("tx_valid", want.tx_valid, rsp_payload.tx_valid);
            check_field("tx_char", want.tx_char, rsp_payload.tx_char);
            check_field("rx_irq", want.rx_irq, rsp_payload.rx_irq);
            check_field("irq_vector", want.irq_vector, rsp_payload.irq_vector);
         end
      end
   end

   // response back-pressure in random bursts
   always @(posedge clock) begin
      if (reset || rsp_calm) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 6) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(0, 12);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // drive one item and hold it until accepted, then maybe pause
   task automatic send_item(input req_type item);
      req_payload <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      if (!req_calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   task automatic wait_until_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (responses_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_device_id(input logic [15:0] value);
      wait_until_idle();
      csr_wr_data <= value;
      csr_wr_en <= 1'b1;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic req_type make_order(input logic [2:0] cmd, input logic [3:0] func,
                                          input logic [15:0] a);
      req_type r;
      r = '0;
      r.cmd = cmd;
      r.func = func;
      r.a_data = a;
      return r;
   endfunction

   // random content, time fields either legal or over the whole width
   function automatic req_type random_item(input logic [2:0] cmd, input logic [3:0] func);
      req_type r;
      r.cmd = cmd;
      r.func = func;
      r.a_data = 16'($urandom);
      r.rx_char = 7'($urandom);
      if ($urandom_range(0, 1) == 0) begin
         r.year_since_1900 = 8'($urandom_range(0, 199));
         r.month_zero_based = 4'($urandom_range(0, 11));
         r.day_of_month = 5'($urandom_range(1, 31));
         r.weekday_zero_based = 3'($urandom_range(0, 6));
         r.hour_of_day = 5'($urandom_range(0, 23));
         r.minute_of_hour = 6'($urandom_range(0, 59));
         r.second_of_minute = 6'($urandom_range(0, 60));
      end else begin
         r.year_since_1900 = 8'($urandom);
         r.month_zero_based = 4'($urandom);
         r.day_of_month = 5'($urandom);
         r.weekday_zero_based = 3'($urandom);
         r.hour_of_day = 5'($urandom);
         r.minute_of_hour = 6'($urandom);
         r.second_of_minute = 6'($urandom);
      end
      return r;
   endfunction

   // every order at least once, field extremes, empty and non-empty queue cases
   task automatic test_directed_orders();
      req_type r;
      send_item(make_order(CMD_INPUT, F_INA_ID, 16'h0000));
      send_item(make_order(CMD_INPUT, F_INA_CLOCK, 16'h0000));
      send_item(make_order(CMD_INPUT, F_INA_CHAR_OR, 16'hffff));
      send_item(make_order(CMD_SKIP, F_SKP_RX_READY, 16'h0000));
      send_item(make_order(CMD_SKIP, F_SKP_ANY, 16'hffff));
      send_item(make_order(CMD_CONTROL, F_CTL_ECHO_ON, 16'h0000));
      send_item(make_order(CMD_OUTPUT, F_OTA_RX_VEC, 16'hffff));
      // mask on with an empty queue raises nothing
      send_item(make_order(CMD_CONTROL, F_CTL_MASK_ON, 16'h0000));
      r = make_order(CMD_KEYBOARD, 4'h0, 16'h0000);
      r.rx_char = 7'h7f;
      send_item(r);
      r.rx_char = 7'h00;
      send_item(r);
      send_item(make_order(CMD_SKIP, F_SKP_RX_READY, 16'h0000));
      send_item(make_order(CMD_INPUT, F_INA_CHAR_OR, 16'hffff));
      send_item(make_order(CMD_INPUT, F_INA_CHAR_LD, 16'hffff));
      send_item(make_order(CMD_CONTROL, F_CTL_MASK_OFF, 16'h0000));
      send_item(make_order(CMD_CONTROL, F_CTL_ECHO_OFF, 16'h0000));
      send_item(make_order(CMD_CONTROL, F_CTL_NOP, 16'hffff));
      send_item(make_order(CMD_OUTPUT, F_OTA_REG0, 16'hffff));
      send_item(make_order(CMD_OUTPUT, F_OTA_REG3, 16'ha5a5));
      send_item(make_order(CMD_INPUT, F_INA_REG0, 16'h0000));
      send_item(make_order(CMD_INPUT, F_INA_REG3, 16'h0000));
      send_item(make_order(CMD_OUTPUT, F_OTA_CHAR, 16'hffff));
      // snapshot at the top of every time field, leap second clipped
      r = make_order(CMD_OUTPUT, F_OTA_CLOCK, 16'h0000);
      r.year_since_1900 = 8'd127;
      r.month_zero_based = 4'd11;
      r.day_of_month = 5'd31;
      r.weekday_zero_based = 3'd6;
      r.hour_of_day = 5'd23;
      r.minute_of_hour = 6'd59;
      r.second_of_minute = 6'd60;
      send_item(r);
      send_item(make_order(CMD_INPUT, F_INA_CLOCK, 16'h0000));
      send_item(make_order(CMD_INPUT, F_INA_CLOCK, 16'h0000));
      // nonzero write ends the snapshot and sets the transmit vector
      send_item(make_order(CMD_OUTPUT, F_OTA_CLOCK, 16'hffff));
      send_item(make_order(CMD_INPUT, F_INA_CLOCK, 16'h0000));
      send_item(make_order(CMD_CONTROL, F_CTL_MASK_OFF2, 16'h0000));
      send_item(make_order(CMD_UNUSED_LO, 4'hf, 16'hffff));
      send_item(make_order(CMD_UNUSED_HI, 4'h0, 16'h0000));
   endtask

   // device id extremes and a random value, each read back by the id order
   task automatic test_device_id();
      write_device_id(16'h0000);
      send_item(make_order(CMD_INPUT, F_INA_ID, 16'h0000));
      write_device_id(16'hffff);
      send_item(make_order(CMD_INPUT, F_INA_ID, 16'hffff));
      write_device_id(16'($urandom));
      send_item(make_order(CMD_INPUT, F_INA_ID, 16'h0000));
   endtask

   task automatic run_random_sequence();
      int unsigned n;
      case ($urandom_range(0, 9))
         0, 1: begin
            // keyboard burst, sometimes past full, then pops
            if ($urandom_range(0, 1) == 0)
               send_item(random_item(CMD_CONTROL,
                                     $urandom_range(0, 1) ? F_CTL_ECHO_ON : F_CTL_ECHO_OFF));
            n = $urandom_range(1, QUEUE_DEPTH + 4);
            repeat (n) send_item(random_item(CMD_KEYBOARD, 4'($urandom)));
            if ($urandom_range(0, 2) == 0)
               send_item(random_item(CMD_SKIP, F_SKP_RX_READY));
            repeat ($urandom_range(1, n + 2))
               send_item(random_item(CMD_INPUT,
                                     $urandom_range(0, 1) ? F_INA_CHAR_OR : F_INA_CHAR_LD));
         end
         2: begin
            req_type r;
            r = random_item(CMD_OUTPUT, F_OTA_CLOCK);
            r.a_data = 16'h0000;
            send_item(r);
            repeat ($urandom_range(1, 10)) send_item(random_item(CMD_INPUT, F_INA_CLOCK));
            if ($urandom_range(0, 3) == 0)
               send_item(random_item(CMD_OUTPUT, F_OTA_CLOCK));
         end
         3: begin
            logic [1:0] k;
            k = 2'($urandom);
            send_item(random_item(CMD_OUTPUT, F_OTA_REG0 + k));
            send_item(random_item(CMD_INPUT, F_INA_REG0 + 2'($urandom)));
         end
         4: begin
            case ($urandom_range(0, 5))
               0: send_item(random_item(CMD_CONTROL, F_CTL_ECHO_OFF));
               1: send_item(random_item(CMD_CONTROL, F_CTL_ECHO_ON));
               2, 3: send_item(random_item(CMD_CONTROL, F_CTL_MASK_ON));
               4: send_item(random_item(CMD_CONTROL, F_CTL_MASK_OFF));
               default: send_item(random_item(CMD_CONTROL, F_CTL_MASK_OFF2));
            endcase
         end
         5: begin
            // interrupt path: new vector, mask on, characters arrive
            send_item(random_item(CMD_OUTPUT, F_OTA_RX_VEC));
            if ($urandom_range(0, 1) == 0) send_item(random_item(CMD_CONTROL, F_CTL_MASK_ON));
            repeat ($urandom_range(1, 3)) send_item(random_item(CMD_KEYBOARD, 4'($urandom)));
            if ($urandom_range(0, 1) == 0) send_item(random_item(CMD_CONTROL, F_CTL_MASK_ON));
         end
         6, 7: begin
            repeat ($urandom_range(1, 6)) send_item(random_item(3'($urandom), 4'($urandom)));
         end
         8: begin
            send_item(random_item(CMD_SKIP, $urandom_range(0, 1) ? F_SKP_RX_READY
                                                                   : 4'($urandom)));
         end
         default: begin
            case ($urandom_range(0, 4))
               0: send_item(random_item(CMD_INPUT, F_INA_ID));
               1: send_item(random_item(CMD_OUTPUT, F_OTA_CHAR));
               2: send_item(random_item(CMD_OUTPUT, F_OTA_NOP));
               3: send_item(random_item(CMD_INPUT, 4'($urandom)));
               default: send_item(random_item(3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)),
                                              4'($urandom)));
            endcase
         end
      endcase
   endtask

   // mostly well-formed order sequences, some noise, device id changed now and then
   task automatic test_random_traffic(input int unsigned count);
      int unsigned stop_at;
      int unsigned next_write;
      int unsigned pick;
      stop_at = items_sent + count;
      next_write = items_sent + 350;
      while (items_sent < stop_at) begin
         if (items_sent >= next_write) begin
            pick = $urandom_range(0, 3);
            write_device_id(pick == 0 ? 16'h0000 : pick == 1 ? 16'hffff : 16'($urandom));
            next_write = items_sent + 350;
         end
         // switch between idle-heavy and idle-free stretches
         if ($urandom_range(0, 15) == 0) begin
            req_calm = ($urandom_range(0, 2) == 0);
            rsp_calm = ($urandom_range(0, 2) == 0);
         end
         run_random_sequence();
      end
   endtask

   // last stretch at full rate on both sides
   task automatic test_quiet_tail(input int unsigned count);
      int unsigned stop_at;
      req_calm = 1'b1;
      rsp_calm = 1'b1;
      stop_at = items_sent + count;
      while (items_sent < stop_at) run_random_sequence();
   endtask

   initial begin
      clear_model();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed_orders();
      test_device_id();
      test_random_traffic(1620);
      test_quiet_tail(100);
      wait_until_idle();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && responses_due.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // run limit
   initial begin
      #20_000_000;
      $display("timeout with %0d responses outstanding", responses_due.size());
      $display("Mismatches found");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+src
src/ccr_pkg.sv
src/ccr_ram.sv
src/console_controller_registers_unit.sv
src/ccr_checker.sv
tb/tb_console_controller_registers_unit.sv
